// ===== rtl/sfpd_pkg.sv =====
// Package for the sync frame PWM deframer.
// Frame layout constants and the control type for the window cells.
// Standalone; used by sfpd_cell, sync_frame_pwm_deframer and the bench.
package sfpd_pkg;

  localparam int FRAME_BYTES = 22;
  localparam int CHECK_POS   = 21;
  localparam int NUM_PWM     = 8;
  localparam int FILL_W      = 5;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] PAYLOAD_LEN = 8'd16;
  localparam logic [7:0] PWM_TYPE    = 8'h01;

  localparam logic [FILL_W-1:0] LAST_POS  = 5'd21;
  localparam logic [FILL_W-1:0] FILL_DROP1 = 5'd21;
  localparam logic [FILL_W-1:0] FILL_DROP2 = 5'd20;

  // Byte offsets inside a frame
  localparam int TYPE_POS = 2;
  localparam int SEQ_POS  = 3;
  localparam int LEN_POS  = 4;
  localparam int PWM_POS  = 5;

  // Window movement for one cycle
  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_ONE  = 2'd1;
  localparam logic [1:0] SH_TWO  = 2'd2;

  typedef struct packed {
    logic [1:0] shift;  // move the window toward the front by 0, 1 or 2
    logic       wr;     // this cell is the write slot for the incoming byte
  } cell_ctl_t;

endpackage

// ===== rtl/sync_frame_pwm_deframer.sv =====
// Top level of the sync frame PWM deframer: a row of 22 byte cells plus
// frame checks, running XOR and the result registers.
// Depends on sfpd_pkg and sfpd_cell.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, in_byte             | into block
//  result  | out_valid, out_stall, out_seq_num,      | out of block
//          | out_pwm_0 .. out_pwm_7                  |
//
// One byte is taken every cycle while in_stall is low; a frame result is
// registered when the byte that completes it is taken. The checksum is kept
// as a running XOR, so the frame check is one compare per cycle and the
// window shift is a 3-way mux in each cell. Reset clears the fill count,
// the running XOR and both result valids. A second result register catches
// a frame while the first waits; the input stalls only while both are full,
// and frees in the cycle after the result side takes the first.
module sync_frame_pwm_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_seq_num,
  output logic [15:0] out_pwm_0,
  output logic [15:0] out_pwm_1,
  output logic [15:0] out_pwm_2,
  output logic [15:0] out_pwm_3,
  output logic [15:0] out_pwm_4,
  output logic [15:0] out_pwm_5,
  output logic [15:0] out_pwm_6,
  output logic [15:0] out_pwm_7
);

  localparam int NB = sfpd_pkg::FRAME_BYTES;

  logic [sfpd_pkg::FILL_W-1:0] fill_r, fill_nxt, pos;
  logic [7:0]                  xacc_r, xacc_nxt;
  logic                        accept, full, hdr_bad, chk_bad, emit;
  logic [1:0]                  shift;
  logic [7:0]                  w [0:NB+1];
  sfpd_pkg::cell_ctl_t         ctl [0:NB-1];

  logic                        out_valid_r, skid_valid_r, out_move;
  logic [7:0]                  seq_r, skid_seq_r, frm_seq;
  logic [15:0]                 pwm_r [0:sfpd_pkg::NUM_PWM-1];
  logic [15:0]                 skid_pwm_r [0:sfpd_pkg::NUM_PWM-1];
  logic [15:0]                 frm_pwm [0:sfpd_pkg::NUM_PWM-1];

  assign in_stall = skid_valid_r;
  assign accept   = in_valid & ~in_stall;
  // Output register is free or being taken this cycle
  assign out_move = ~out_valid_r | ~out_stall;

  // Unreachable from reset, but keep the write slot inside the window
  assign pos  = (fill_r > sfpd_pkg::LAST_POS) ? sfpd_pkg::LAST_POS : fill_r;
  assign full = (pos == sfpd_pkg::LAST_POS);

  assign hdr_bad = (w[0] != sfpd_pkg::SYNC_FIRST) || (w[1] != sfpd_pkg::SYNC_SECOND);
  // xacc_r holds the XOR of the 21 stored bytes; the new byte is the checksum
  assign chk_bad = (w[sfpd_pkg::LEN_POS] != sfpd_pkg::PAYLOAD_LEN) || (in_byte != xacc_r);
  assign emit    = accept && full && !hdr_bad && !chk_bad
                   && (w[sfpd_pkg::TYPE_POS] == sfpd_pkg::PWM_TYPE);

  always_comb begin
    shift    = sfpd_pkg::SH_NONE;
    fill_nxt = fill_r;
    xacc_nxt = xacc_r;
    if (accept) begin
      if (!full) begin
        fill_nxt = pos + 5'd1;
        xacc_nxt = xacc_r ^ in_byte;
      end else if (hdr_bad) begin
        shift    = sfpd_pkg::SH_ONE;
        fill_nxt = sfpd_pkg::FILL_DROP1;
        xacc_nxt = xacc_r ^ in_byte ^ w[0];
      end else if (chk_bad) begin
        shift    = sfpd_pkg::SH_TWO;
        fill_nxt = sfpd_pkg::FILL_DROP2;
        xacc_nxt = xacc_r ^ in_byte ^ w[0] ^ w[1];
      end else begin
        fill_nxt = '0;
        xacc_nxt = '0;
      end
    end
  end

  // Past-the-end neighbors feed slots whose content is not yet valid
  assign w[NB]   = '0;
  assign w[NB+1] = '0;

  for (genvar i = 0; i < NB; i++) begin : g_cell
    assign ctl[i].shift = shift;
    assign ctl[i].wr    = accept && (pos == i[sfpd_pkg::FILL_W-1:0]);

    sfpd_cell u_cell (
      .clk       (clk),
      .ctl_i     (ctl[i]),
      .in_byte_i (in_byte),
      .nb1_i     (w[i+1]),
      .nb2_i     (w[i+2]),
      .w_o       (w[i])
    );
  end

  always_comb begin
    frm_seq = w[sfpd_pkg::SEQ_POS];
    for (int k = 0; k < sfpd_pkg::NUM_PWM; k++) begin
      frm_pwm[k] = {w[sfpd_pkg::PWM_POS + 2*k + 1], w[sfpd_pkg::PWM_POS + 2*k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      xacc_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      xacc_r <= xacc_nxt;
      if (out_move) begin
        out_valid_r  <= skid_valid_r | emit;
        skid_valid_r <= 1'b0;
      end else if (emit) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      skid_seq_r <= frm_seq;
      for (int k = 0; k < sfpd_pkg::NUM_PWM; k++) begin
        skid_pwm_r[k] <= frm_pwm[k];
      end
    end
    // Advance the waiting item first; a new frame only lands when none waits
    if (out_move) begin
      if (skid_valid_r) begin
        seq_r <= skid_seq_r;
        for (int k = 0; k < sfpd_pkg::NUM_PWM; k++) begin
          pwm_r[k] <= skid_pwm_r[k];
        end
      end else if (emit) begin
        seq_r <= frm_seq;
        for (int k = 0; k < sfpd_pkg::NUM_PWM; k++) begin
          pwm_r[k] <= frm_pwm[k];
        end
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_seq_num = seq_r;
  assign out_pwm_0   = pwm_r[0];
  assign out_pwm_1   = pwm_r[1];
  assign out_pwm_2   = pwm_r[2];
  assign out_pwm_3   = pwm_r[3];
  assign out_pwm_4   = pwm_r[4];
  assign out_pwm_5   = pwm_r[5];
  assign out_pwm_6   = pwm_r[6];
  assign out_pwm_7   = pwm_r[7];

endmodule

// ===== rtl/sfpd_cell.sv =====
// One byte slot of the receive window.
// Keeps its byte, takes the incoming byte or takes a value from one of its two downstream neighbors.
// Depends on sfpd_pkg.
module sfpd_cell (
  input  logic                  clk,
  input  sfpd_pkg::cell_ctl_t   ctl_i,
  input  logic [7:0]            in_byte_i,
  input  logic [7:0]            nb1_i,
  input  logic [7:0]            nb2_i,
  output logic [7:0]            w_o
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // Current view: the incoming byte overlays this slot when it is the write slot
  assign w_o = ctl_i.wr ? in_byte_i : byte_r;

  always_comb begin
    case (ctl_i.shift)
      sfpd_pkg::SH_NONE: byte_nxt = w_o;
      sfpd_pkg::SH_ONE:  byte_nxt = nb1_i;
      sfpd_pkg::SH_TWO:  byte_nxt = nb2_i;
      default:           byte_nxt = byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

// ===== rtl/sfpd_checker.sv =====
// Port-level checks for the sync frame PWM deframer, bound to the top level.
// Depends only on the top level's ports.
module sfpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_seq_num,
  input logic [15:0] out_pwm_0
);

  // A held result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A new result only follows an accepted item
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an accepted item");

  // Input backpressure only while results are held
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  // A stalled result keeps its fields
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_seq_num) && $stable(out_pwm_0))
    else $error("result fields changed while stalled");

endmodule

bind sync_frame_pwm_deframer sfpd_checker u_sfpd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_seq_num (out_seq_num),
  .out_pwm_0   (out_pwm_0)
);

// ===== bench/testbench.sv =====
// Self-checking bench for sync_frame_pwm_deframer: byte stream in, PWM frames out.
// Depends on sfpd_pkg and the RTL top level; the frame predictor lives in this file.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] frame_bytes_t [sfpd_pkg::FRAME_BYTES];

  typedef struct packed {
    logic [7:0]                         seq;
    logic [sfpd_pkg::NUM_PWM-1:0][15:0] duty;
  } pwm_frame_t;

  typedef enum int {
    BAD_SYNC_FIRST,
    BAD_SYNC_SECOND,
    BAD_LENGTH,
    BAD_CHECKSUM,
    BAD_BODY
  } frame_fault_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_seq_num;
  logic [15:0] out_pwm [sfpd_pkg::NUM_PWM];

  sync_frame_pwm_deframer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_seq_num(out_seq_num),
    .out_pwm_0  (out_pwm[0]),
    .out_pwm_1  (out_pwm[1]),
    .out_pwm_2  (out_pwm[2]),
    .out_pwm_3  (out_pwm[3]),
    .out_pwm_4  (out_pwm[4]),
    .out_pwm_5  (out_pwm[5]),
    .out_pwm_6  (out_pwm[6]),
    .out_pwm_7  (out_pwm[7])
  );

  // Predictor state: receive window and its fill level
  frame_bytes_t rx_win;
  int           rx_fill;
  pwm_frame_t   pwm_expect_q [$];

  int  error_count;
  int  bytes_sent;
  int  frames_checked;
  bit  in_gap_on;
  bit  out_gap_on;
  bit  hold_on;
  int  out_wait_cnt;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] frame_xor(input frame_bytes_t f);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < sfpd_pkg::CHECK_POS; i++) acc ^= f[i];
    return acc;
  endfunction

  // Take one accepted byte into the window and queue the frame it completes, if any
  function automatic void absorb_byte(input logic [7:0] b);
    int         pos;
    int         drop;
    pwm_frame_t frm;
    pos = (rx_fill >= sfpd_pkg::FRAME_BYTES) ? sfpd_pkg::FRAME_BYTES - 1 : rx_fill;
    rx_win[pos] = b;
    rx_fill = pos + 1;
    drop = 0;
    if (rx_fill == sfpd_pkg::FRAME_BYTES) begin
      if (rx_win[0] != sfpd_pkg::SYNC_FIRST || rx_win[1] != sfpd_pkg::SYNC_SECOND) begin
        drop = 1;
      end else if (rx_win[sfpd_pkg::LEN_POS] != sfpd_pkg::PAYLOAD_LEN ||
                   rx_win[sfpd_pkg::CHECK_POS] != frame_xor(rx_win)) begin
        drop = 2;
      end else begin
        rx_fill = 0;
        if (rx_win[sfpd_pkg::TYPE_POS] == sfpd_pkg::PWM_TYPE) begin
          frm.seq = rx_win[sfpd_pkg::SEQ_POS];
          for (int k = 0; k < sfpd_pkg::NUM_PWM; k++)
            frm.duty[k] = {rx_win[sfpd_pkg::PWM_POS + 2 * k + 1],
                           rx_win[sfpd_pkg::PWM_POS + 2 * k]};
          pwm_expect_q.push_back(frm);
        end
      end
    end
    if (drop > 0) begin
      for (int i = 0; i < rx_fill - drop; i++) rx_win[i] = rx_win[i + drop];
      rx_fill -= drop;
    end
  endfunction

  function automatic frame_bytes_t build_frame(
      input logic [7:0] ftype, input logic [7:0] seq,
      input logic [sfpd_pkg::NUM_PWM-1:0][15:0] duty);
    frame_bytes_t f;
    f[0]                  = sfpd_pkg::SYNC_FIRST;
    f[1]                  = sfpd_pkg::SYNC_SECOND;
    f[sfpd_pkg::TYPE_POS] = ftype;
    f[sfpd_pkg::SEQ_POS]  = seq;
    f[sfpd_pkg::LEN_POS]  = sfpd_pkg::PAYLOAD_LEN;
    for (int k = 0; k < sfpd_pkg::NUM_PWM; k++) begin
      f[sfpd_pkg::PWM_POS + 2 * k]     = duty[k][7:0];
      f[sfpd_pkg::PWM_POS + 2 * k + 1] = duty[k][15:8];
    end
    f[sfpd_pkg::CHECK_POS] = frame_xor(f);
    return f;
  endfunction

  function automatic logic [sfpd_pkg::NUM_PWM-1:0][15:0] random_duty();
    logic [sfpd_pkg::NUM_PWM-1:0][15:0] d;
    for (int k = 0; k < sfpd_pkg::NUM_PWM; k++) d[k] = 16'($urandom_range(0, 65535));
    return d;
  endfunction

  function automatic frame_bytes_t random_frame(input logic [7:0] ftype);
    return build_frame(ftype, 8'($urandom_range(0, 255)), random_duty());
  endfunction

  // Entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_gap_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (in_stall);
    absorb_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_bytes_t f, input int count);
    for (int i = 0; i < count; i++) send_byte(f[i]);
  endtask

  task automatic send_faulty_frame(input frame_fault_t fault);
    frame_bytes_t f;
    int           pos;
    f = random_frame(sfpd_pkg::PWM_TYPE);
    case (fault)
      BAD_SYNC_FIRST:  f[0] ^= 8'($urandom_range(1, 255));
      BAD_SYNC_SECOND: f[1] ^= 8'($urandom_range(1, 255));
      BAD_LENGTH: begin
        // keep the checksum consistent so only the length is wrong
        f[sfpd_pkg::LEN_POS] ^= 8'($urandom_range(1, 255));
        f[sfpd_pkg::CHECK_POS] = frame_xor(f);
      end
      BAD_CHECKSUM:    f[sfpd_pkg::CHECK_POS] ^= 8'($urandom_range(1, 255));
      default: begin
        pos = $urandom_range(sfpd_pkg::TYPE_POS, sfpd_pkg::CHECK_POS - 1);
        f[pos] ^= 8'($urandom_range(1, 255));
      end
    endcase
    send_frame(f, sfpd_pkg::FRAME_BYTES);
  endtask

  // Result side: draw a wait after each item, plus the long hold when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_on || out_wait_cnt > 0) begin
        out_stall = 1'b1;
        if (out_wait_cnt > 0) out_wait_cnt--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pwm_expect_q.size() == 0) begin
        $error("unexpected PWM frame: seq_num %h", out_seq_num);
        error_count++;
      end else begin
        pwm_frame_t want;
        want = pwm_expect_q.pop_front();
        if (out_seq_num !== want.seq) begin
          $error("seq_num mismatch: expected %h, actual %h", want.seq, out_seq_num);
          error_count++;
        end
        for (int k = 0; k < sfpd_pkg::NUM_PWM; k++) begin
          if (out_pwm[k] !== want.duty[k]) begin
            $error("pwm_%0d mismatch: expected %h, actual %h", k, want.duty[k], out_pwm[k]);
            error_count++;
          end
        end
      end
      frames_checked++;
      out_wait_cnt = out_gap_on ? $urandom_range(0, 3) : 0;
    end
  end

  task automatic test_pwm_frames();
    send_frame(build_frame(sfpd_pkg::PWM_TYPE, 8'h00, '0), sfpd_pkg::FRAME_BYTES);
    send_frame(build_frame(sfpd_pkg::PWM_TYPE, 8'hFF, '1), sfpd_pkg::FRAME_BYTES);
    // other types pass the checks but produce nothing
    send_frame(build_frame(8'h00, 8'h5A, '1), sfpd_pkg::FRAME_BYTES);
    send_frame(build_frame(8'hFF, 8'hA5, random_duty()), sfpd_pkg::FRAME_BYTES);
    send_frame(random_frame(sfpd_pkg::PWM_TYPE), sfpd_pkg::FRAME_BYTES);
  endtask

  task automatic test_frame_faults();
    frame_fault_t fault;
    fault = fault.first();
    do begin
      send_faulty_frame(fault);
      send_frame(random_frame(sfpd_pkg::PWM_TYPE), sfpd_pkg::FRAME_BYTES);
      fault = fault.next();
    end while (fault != fault.first());
  endtask

  task automatic test_backpressure();
    fork
      begin
        @(posedge clk);
        hold_on = 1'b1;
        repeat (300) @(posedge clk);
        hold_on = 1'b0;
      end
      for (int n = 0; n < 4; n++)
        send_frame(random_frame(sfpd_pkg::PWM_TYPE), sfpd_pkg::FRAME_BYTES);
    join
  endtask

  task automatic test_random_stream(input int n_bytes);
    int           stop_at;
    int           pick;
    logic [7:0]   ftype;
    frame_bytes_t f;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      in_gap_on  = ($urandom_range(0, 4) != 0);
      out_gap_on = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(random_frame(sfpd_pkg::PWM_TYPE), sfpd_pkg::FRAME_BYTES);
      end else if (pick < 68) begin
        ftype = 8'($urandom_range(0, 255));
        if (ftype == sfpd_pkg::PWM_TYPE) ftype = 8'h02;
        send_frame(random_frame(ftype), sfpd_pkg::FRAME_BYTES);
      end else if (pick < 82) begin
        send_faulty_frame(frame_fault_t'($urandom_range(BAD_SYNC_FIRST, BAD_BODY)));
      end else if (pick < 90) begin
        // cut off early, the next frame has to resync behind it
        f = random_frame(sfpd_pkg::PWM_TYPE);
        send_frame(f, $urandom_range(1, sfpd_pkg::FRAME_BYTES - 1));
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(($urandom_range(0, 3) == 0) ? sfpd_pkg::SYNC_FIRST
                                                : 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : main
    int waited;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    hold_on        = 1'b0;
    out_wait_cnt   = 0;
    in_gap_on      = 1'b1;
    out_gap_on     = 1'b1;
    rx_fill        = 0;
    error_count    = 0;
    bytes_sent     = 0;
    frames_checked = 0;
    for (int i = 0; i < sfpd_pkg::FRAME_BYTES; i++) rx_win[i] = 8'h00;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_pwm_frames();
    test_frame_faults();
    test_backpressure();
    test_random_stream(1330);

    in_valid = 1'b0;
    waited = 0;
    while (pwm_expect_q.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (pwm_expect_q.size() != 0) begin
      $error("%0d expected PWM frames never came out", pwm_expect_q.size());
      error_count++;
    end

    $display("Sent %0d bytes (good, foreign-type, faulty, cut-off frames and noise),",
             bytes_sent);
    $display("checked %0d PWM frames under random gaps and a long result hold.",
             frames_checked);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/sfpd_pkg.sv
rtl/sfpd_cell.sv
rtl/sync_frame_pwm_deframer.sv
rtl/sfpd_checker.sv
bench/testbench.sv
